// File: rtl/masked_event_match_table_defines.svh
// Assertion macros for the masked event match table.
// Included by modules that carry concurrent checks; expects clk and rst_n in scope.
`ifndef MASKED_EVENT_MATCH_TABLE_DEFINES_SVH
`define MASKED_EVENT_MATCH_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MMT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define MMT_ASSERT(lbl, prop, msg)
`define MMT_NEVER(lbl, expr, msg)
`endif
`endif

// File: rtl/mmt_pkg.sv
// Shared types, constants and helpers for the masked event match table.
// No dependencies.
`default_nettype none
package mmt_pkg;

    localparam int MAX_EVENT_BYTES    = 8;
    localparam int ENTRIES_PER_LENGTH = 32;

    localparam int LEN_W   = 4;
    localparam int CNT_W   = 6;
    localparam int EV_W    = 64;
    localparam int EV_BYTES = EV_W / 8;
    localparam int TYPE_W  = 8;
    localparam int VAL_W   = 32;
    localparam int BANK_W  = (MAX_EVENT_BYTES > 1) ? $clog2(MAX_EVENT_BYTES) : 1;
    localparam int DEPTH   = MAX_EVENT_BYTES * ENTRIES_PER_LENGTH;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [LEN_W-1:0] MAX_LEN   = LEN_W'(MAX_EVENT_BYTES);
    localparam logic [CNT_W-1:0] BANK_SIZE = CNT_W'(ENTRIES_PER_LENGTH);
    localparam logic [7:0]       WILDCARD_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        CMD_ADD        = 2'd0,
        CMD_LOOKUP     = 2'd1,
        CMD_WALK_RESET = 2'd2,
        CMD_WALK_NEXT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_LEN = 2'd1,
        ST_FULL    = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef struct packed {
        logic [EV_W-1:0]   pattern;
        logic [EV_W-1:0]   mask;
        logic [TYPE_W-1:0] etype;
        logic [VAL_W-1:0]  value;
    } entry_t;

    typedef struct packed {
        status_t           status;
        logic [TYPE_W-1:0] etype;
        logic [VAL_W-1:0]  value;
        logic [LEN_W-1:0]  length;
        logic [EV_W-1:0]   pattern;
        logic [EV_W-1:0]   mask;
        logic              last;
    } beat_t;

    function automatic logic bad_length(input logic [LEN_W-1:0] len);
        return (len == '0) || (len > MAX_LEN);
    endfunction

    function automatic logic [EV_W-1:0] len_mask(input logic [LEN_W-1:0] len);
        logic [EV_W-1:0] m;
        for (int j = 0; j < EV_BYTES; j++) begin
            m[8*j +: 8] = (LEN_W'(j) < len) ? 8'hFF : 8'h00;
        end
        return m;
    endfunction

    function automatic logic entry_hit(input entry_t e, input logic [EV_W-1:0] ev,
                                       input logic [LEN_W-1:0] len);
        logic hit;
        hit = 1'b1;
        for (int j = 0; j < EV_BYTES; j++) begin
            if ((LEN_W'(j) < len) && (e.mask[8*j +: 8] != WILDCARD_BYTE)
                    && (e.pattern[8*j +: 8] != ev[8*j +: 8])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic logic [ADDR_W-1:0] slot_addr(input logic [BANK_W-1:0] bank,
                                                    input logic [CNT_W-1:0] pos);
        return ADDR_W'(bank) * ADDR_W'(ENTRIES_PER_LENGTH) + ADDR_W'(pos);
    endfunction

endpackage
`default_nettype wire

// File: rtl/mmt_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module mmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/mmt_ctrl.sv
// Command sequencer: bank counts, lookup scan over the entry RAM, enumeration walk.
// Depends on mmt_pkg and masked_event_match_table_defines.svh.
`default_nettype none
`include "masked_event_match_table_defines.svh"
module mmt_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    command,
    input  wire logic [mmt_pkg::LEN_W-1:0]     length,
    input  wire logic [mmt_pkg::EV_W-1:0]      event_bytes,
    input  wire logic [mmt_pkg::EV_W-1:0]      mask_bytes,
    input  wire logic [mmt_pkg::TYPE_W-1:0]    entry_type,
    input  wire logic [mmt_pkg::VAL_W-1:0]     entry_value,
    output logic                               ram_we,
    output logic [mmt_pkg::ADDR_W-1:0]         ram_wr_addr,
    output mmt_pkg::entry_t                    ram_wr_data,
    output logic [mmt_pkg::ADDR_W-1:0]         ram_rd_addr,
    input  wire mmt_pkg::entry_t               ram_rd_data,
    output logic                               beat_valid,
    output mmt_pkg::beat_t                     beat,
    input  wire logic                          beat_take
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_END,
        S_WALK,
        S_WALK_RD
    } state_t;

    state_t                          state_reg, state_next;
    logic [mmt_pkg::CNT_W-1:0]       bank_cnt_reg [mmt_pkg::MAX_EVENT_BYTES];
    logic [mmt_pkg::CNT_W-1:0]       bank_cnt_next [mmt_pkg::MAX_EVENT_BYTES];
    logic [mmt_pkg::LEN_W-1:0]       walk_bank_reg, walk_bank_next;
    logic [mmt_pkg::CNT_W-1:0]       walk_pos_reg, walk_pos_next;
    logic [mmt_pkg::BANK_W-1:0]      scan_bank_reg, scan_bank_next;
    logic [mmt_pkg::LEN_W-1:0]       scan_len_reg, scan_len_next;
    logic [mmt_pkg::EV_W-1:0]        ev_reg, ev_next;
    logic [mmt_pkg::CNT_W-1:0]       n_reg, n_next;
    logic [mmt_pkg::CNT_W-1:0]       idx_reg, idx_next;
    logic                            pend_v_reg, pend_v_next;
    mmt_pkg::beat_t                  pend_reg, pend_next;
    logic                            res_v_reg, res_v_next;
    mmt_pkg::beat_t                  res_reg, res_next;

    logic                            accept;
    logic                            res_free;
    logic [mmt_pkg::BANK_W-1:0]      len_bank;
    logic [mmt_pkg::BANK_W-1:0]      walk_idx;
    logic [mmt_pkg::CNT_W-1:0]       cnt_sel;
    logic [mmt_pkg::CNT_W-1:0]       walk_step;
    logic                            hit;
    mmt_pkg::beat_t                  hit_beat;
    mmt_pkg::cmd_t                   cmd;

    function automatic mmt_pkg::beat_t blank_beat(input mmt_pkg::status_t st);
        mmt_pkg::beat_t b;
        b = '0;
        b.status = st;
        b.last = 1'b1;
        return b;
    endfunction

    assign cmd       = mmt_pkg::cmd_t'(command);
    assign in_stall  = (state_reg != S_IDLE) || res_v_reg;
    assign accept    = in_valid && !in_stall;
    assign res_free  = !res_v_reg || beat_take;
    assign len_bank  = mmt_pkg::BANK_W'(length - mmt_pkg::LEN_W'(1));
    assign walk_idx  = walk_bank_reg[mmt_pkg::BANK_W-1:0];
    assign cnt_sel   = bank_cnt_reg[len_bank];
    assign walk_step = walk_pos_reg + mmt_pkg::CNT_W'(1);
    assign hit       = mmt_pkg::entry_hit(ram_rd_data, ev_reg, scan_len_reg);

    always_comb
    begin
        hit_beat         = '0;
        hit_beat.status  = mmt_pkg::ST_OK;
        hit_beat.etype   = ram_rd_data.etype;
        hit_beat.value   = ram_rd_data.value;
        hit_beat.length  = scan_len_reg;
        hit_beat.pattern = ram_rd_data.pattern;
        hit_beat.mask    = ram_rd_data.mask;
        hit_beat.last    = 1'b0;
    end

    always_comb
    begin
        state_next     = state_reg;
        bank_cnt_next  = bank_cnt_reg;
        walk_bank_next = walk_bank_reg;
        walk_pos_next  = walk_pos_reg;
        scan_bank_next = scan_bank_reg;
        scan_len_next  = scan_len_reg;
        ev_next        = ev_reg;
        n_next         = n_reg;
        idx_next       = idx_reg;
        pend_v_next    = pend_v_reg;
        pend_next      = pend_reg;
        res_v_next     = res_v_reg && !beat_take;
        res_next       = res_reg;
        ram_we         = 1'b0;
        ram_wr_addr    = mmt_pkg::slot_addr(len_bank, cnt_sel);
        ram_wr_data.pattern = event_bytes & mmt_pkg::len_mask(length);
        ram_wr_data.mask    = mask_bytes & mmt_pkg::len_mask(length);
        ram_wr_data.etype   = entry_type;
        ram_wr_data.value   = entry_value;
        ram_rd_addr    = mmt_pkg::slot_addr(scan_bank_reg, idx_reg);

        case (state_reg)
            S_IDLE:
            begin
                ram_rd_addr = mmt_pkg::slot_addr(len_bank, '0);
                if (accept)
                begin
                    case (cmd)
                        mmt_pkg::CMD_ADD:
                        begin
                            res_v_next = 1'b1;
                            if (mmt_pkg::bad_length(length))
                            begin
                                res_next = blank_beat(mmt_pkg::ST_BAD_LEN);
                            end
                            else if (cnt_sel >= mmt_pkg::BANK_SIZE)
                            begin
                                res_next = blank_beat(mmt_pkg::ST_FULL);
                            end
                            else
                            begin
                                ram_we = 1'b1;
                                bank_cnt_next[len_bank] = cnt_sel + mmt_pkg::CNT_W'(1);
                                res_next = blank_beat(mmt_pkg::ST_OK);
                            end
                        end
                        mmt_pkg::CMD_LOOKUP:
                        begin
                            if (mmt_pkg::bad_length(length))
                            begin
                                res_v_next = 1'b1;
                                res_next   = blank_beat(mmt_pkg::ST_BAD_LEN);
                            end
                            else if (cnt_sel == '0)
                            begin
                                res_v_next = 1'b1;
                                res_next   = blank_beat(mmt_pkg::ST_NONE);
                            end
                            else
                            begin
                                scan_bank_next = len_bank;
                                scan_len_next  = length;
                                ev_next        = event_bytes;
                                n_next         = cnt_sel;
                                idx_next       = '0;
                                pend_v_next    = 1'b0;
                                state_next     = S_SCAN;
                            end
                        end
                        mmt_pkg::CMD_WALK_RESET:
                        begin
                            walk_bank_next = '0;
                            walk_pos_next  = '1;
                            res_v_next     = 1'b1;
                            res_next       = blank_beat(mmt_pkg::ST_OK);
                        end
                        mmt_pkg::CMD_WALK_NEXT:
                        begin
                            state_next = S_WALK;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!(hit && pend_v_reg) || res_free)
                begin
                    if (hit)
                    begin
                        if (pend_v_reg)
                        begin
                            res_v_next = 1'b1;
                            res_next   = pend_reg;
                        end
                        pend_v_next = 1'b1;
                        pend_next   = hit_beat;
                    end
                    if (idx_reg == n_reg - mmt_pkg::CNT_W'(1))
                    begin
                        state_next = S_END;
                    end
                    else
                    begin
                        idx_next    = idx_reg + mmt_pkg::CNT_W'(1);
                        ram_rd_addr = mmt_pkg::slot_addr(scan_bank_reg, idx_next);
                    end
                end
            end
            S_END:
            begin
                if (res_free)
                begin
                    res_v_next = 1'b1;
                    if (pend_v_reg)
                    begin
                        res_next      = pend_reg;
                        res_next.last = 1'b1;
                    end
                    else
                    begin
                        res_next = blank_beat(mmt_pkg::ST_NONE);
                    end
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (walk_bank_reg >= mmt_pkg::MAX_LEN)
                begin
                    res_v_next = 1'b1;
                    res_next   = blank_beat(mmt_pkg::ST_NONE);
                    state_next = S_IDLE;
                end
                else if (walk_step >= bank_cnt_reg[walk_idx])
                begin
                    walk_pos_next  = '1;
                    walk_bank_next = walk_bank_reg + mmt_pkg::LEN_W'(1);
                end
                else
                begin
                    walk_pos_next = walk_step;
                    ram_rd_addr   = mmt_pkg::slot_addr(walk_idx, walk_step);
                    state_next    = S_WALK_RD;
                end
            end
            S_WALK_RD:
            begin
                res_v_next       = 1'b1;
                res_next         = blank_beat(mmt_pkg::ST_OK);
                res_next.etype   = ram_rd_data.etype;
                res_next.value   = ram_rd_data.value;
                res_next.length  = walk_bank_reg + mmt_pkg::LEN_W'(1);
                res_next.pattern = ram_rd_data.pattern;
                res_next.mask    = ram_rd_data.mask;
                state_next       = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            for (int i = 0; i < mmt_pkg::MAX_EVENT_BYTES; i++)
            begin
                bank_cnt_reg[i] <= '0;
            end
            walk_bank_reg <= '0;
            walk_pos_reg  <= '1;
            scan_bank_reg <= '0;
            scan_len_reg  <= '0;
            ev_reg        <= '0;
            n_reg         <= '0;
            idx_reg       <= '0;
            pend_v_reg    <= 1'b0;
            pend_reg      <= '0;
            res_v_reg     <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            bank_cnt_reg  <= bank_cnt_next;
            walk_bank_reg <= walk_bank_next;
            walk_pos_reg  <= walk_pos_next;
            scan_bank_reg <= scan_bank_next;
            scan_len_reg  <= scan_len_next;
            ev_reg        <= ev_next;
            n_reg         <= n_next;
            idx_reg       <= idx_next;
            pend_v_reg    <= pend_v_next;
            pend_reg      <= pend_next;
            res_v_reg     <= res_v_next;
            res_reg       <= res_next;
        end
    end

    assign beat_valid = res_v_reg;
    assign beat       = res_reg;

    `MMT_ASSERT(a_scan_idx, (state_reg == S_SCAN) |-> (idx_reg < n_reg), "scan index past bank count")
    `MMT_ASSERT(a_pend_scope, pend_v_reg |-> (state_reg == S_SCAN || state_reg == S_END), "held match outside scan")
    `MMT_ASSERT(a_walk_bank, walk_bank_reg <= mmt_pkg::MAX_LEN, "walk bank out of range")
    `MMT_NEVER(a_we_busy, ram_we && (state_reg != S_IDLE), "entry write outside idle")

endmodule
`default_nettype wire

// File: rtl/masked_event_match_table.sv
// Add, bad length, walk reset: result registered in the sequencer, then in the output register.
// Lookup of a bank with n entries: the scan runs one entry per cycle through the entry RAM
// read port, pausing while a new match meets a held one and the result register is full.
// Next-entry: the walk steps past empty or finished banks, then reads the entry; a new beat
// is taken once the previous result has left the sequencer. Reset clears bank counts and the
// walk; the entry RAM is not cleared and needs no clearing pass.
// Top level: sequencer, entry RAM and output register. Depends on mmt_pkg, mmt_ctrl, mmt_ram.
`default_nettype none
module masked_event_match_table (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [1:0]                        command,
    input  wire logic [mmt_pkg::LEN_W-1:0]         length,
    input  wire logic [mmt_pkg::EV_W-1:0]          event_bytes,
    input  wire logic [mmt_pkg::EV_W-1:0]          mask_bytes,
    input  wire logic [mmt_pkg::TYPE_W-1:0]        entry_type,
    input  wire logic signed [mmt_pkg::VAL_W-1:0]  entry_value,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             status,
    output logic [mmt_pkg::TYPE_W-1:0]             out_type,
    output logic signed [mmt_pkg::VAL_W-1:0]       out_value,
    output logic [mmt_pkg::LEN_W-1:0]              out_length,
    output logic [mmt_pkg::EV_W-1:0]               out_event,
    output logic [mmt_pkg::EV_W-1:0]               out_mask,
    output logic                                   last
);

    logic                          ram_we;
    logic [mmt_pkg::ADDR_W-1:0]    ram_wr_addr;
    mmt_pkg::entry_t               ram_wr_data;
    logic [mmt_pkg::ADDR_W-1:0]    ram_rd_addr;
    mmt_pkg::entry_t               ram_rd_data;
    logic                          beat_valid;
    mmt_pkg::beat_t                beat;
    logic                          beat_take;

    logic                          out_v_reg, out_v_next;
    mmt_pkg::beat_t                out_reg, out_next;

    mmt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (command),
        .length      (length),
        .event_bytes (event_bytes),
        .mask_bytes  (mask_bytes),
        .entry_type  (entry_type),
        .entry_value ($unsigned(entry_value)),
        .ram_we      (ram_we),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .beat_valid  (beat_valid),
        .beat        (beat),
        .beat_take   (beat_take)
    );

    mmt_ram #(
        .WIDTH ($bits(mmt_pkg::entry_t)),
        .DEPTH (mmt_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign beat_take  = beat_valid && (!out_v_reg || !out_stall);
    assign out_v_next = beat_take || (out_v_reg && out_stall);
    assign out_next   = beat_take ? beat : out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
            out_reg   <= '0;
        end
        else
        begin
            out_v_reg <= out_v_next;
            out_reg   <= out_next;
        end
    end

    assign out_valid  = out_v_reg;
    assign status     = out_reg.status;
    assign out_type   = out_reg.etype;
    assign out_value  = $signed(out_reg.value);
    assign out_length = out_reg.length;
    assign out_event  = out_reg.pattern;
    assign out_mask   = out_reg.mask;
    assign last       = out_reg.last;

endmodule
`default_nettype wire

// File: test/tb_masked_event_match_table.sv
// Testbench for masked_event_match_table: directed and random add, lookup and walk commands.
// Results are checked against a built-in table predictor. Depends on mmt_pkg and the RTL.
`default_nettype none
module tb_masked_event_match_table;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 250;
    localparam int HOLD_AFTER = 150;

    typedef struct packed {
        mmt_pkg::cmd_t cmd;
        logic [3:0]    len;
        logic [63:0]   ev;
        logic [63:0]   mk;
        logic [7:0]    ty;
        logic [31:0]   val;
    } table_cmd_t;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          in_valid = 1'b0;
    logic          in_stall;
    mmt_pkg::cmd_t drv_cmd = mmt_pkg::CMD_ADD;
    logic [3:0]    drv_len = '0;
    logic [63:0]   drv_event = '0;
    logic [63:0]   drv_mask = '0;
    logic [7:0]    drv_type = '0;
    logic [31:0]   drv_value = '0;
    logic          out_valid;
    logic          out_stall = 1'b0;
    logic [1:0]    status;
    logic [7:0]    out_type;
    logic [31:0]   out_value;
    logic [3:0]    out_length;
    logic [63:0]   out_event;
    logic [63:0]   out_mask;
    logic          last;

    table_cmd_t     pending_cmds[$];
    mmt_pkg::beat_t results_due[$];
    table_cmd_t     cur = '0;
    logic           offering = 1'b0;
    logic           beat_taken = 1'b0;
    int             send_gap = 0;
    int             stall_left = 0;
    int             hold_left = 0;
    logic           hold_done = 1'b0;
    int             n_offered = 0;
    int             n_in_taken = 0;
    int             n_out = 0;
    int             mismatch_cnt = 0;
    int             idle_cycles = 0;
    mmt_pkg::beat_t got_beat;
    mmt_pkg::beat_t due_beat;

    // table shadow
    int          bank_fill[8] = '{default: 0};
    logic [63:0] pat_mem[8][32];
    logic [63:0] msk_mem[8][32];
    logic [7:0]  typ_mem[8][32];
    logic [31:0] val_mem[8][32];
    int          walk_bank = 0;
    logic [5:0]  walk_pos = 6'h3F;

    // stimulus-side view of stored patterns
    int          gen_fill[8] = '{default: 0};
    logic [63:0] gen_pat[8][32];

    masked_event_match_table uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .command     (drv_cmd),
        .length      (drv_len),
        .event_bytes (drv_event),
        .mask_bytes  (drv_mask),
        .entry_type  (drv_type),
        .entry_value (drv_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .out_type    (out_type),
        .out_value   (out_value),
        .out_length  (out_length),
        .out_event   (out_event),
        .out_mask    (out_mask),
        .last        (last)
    );

    always #6 clk = ~clk;

    function automatic logic [63:0] byte_keep(input int len);
        return (len >= 8) ? {64{1'b1}} : ((64'd1 << (8 * len)) - 64'd1);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] rand_mask(input int wild);
        logic [63:0] m;
        int j;
        m = rand64();
        for (j = 0; j < 8; j++)
        begin
            if ($urandom_range(0, 3) < wild)
                m[8*j +: 8] = mmt_pkg::WILDCARD_BYTE;
        end
        return m;
    endfunction

    function automatic mmt_pkg::beat_t stored_entry(input int b, input int i);
        mmt_pkg::beat_t r;
        r = '0;
        r.status = mmt_pkg::ST_OK;
        r.etype = typ_mem[b][i];
        r.value = val_mem[b][i];
        r.length = 4'(b + 1);
        r.pattern = pat_mem[b][i];
        r.mask = msk_mem[b][i];
        r.last = 1'b1;
        return r;
    endfunction

    function automatic string beat_text(input mmt_pkg::beat_t r);
        return $sformatf("st=%0d type=%h val=%h len=%0d ev=%h mk=%h last=%b",
                         r.status, r.etype, r.value, r.length, r.pattern, r.mask, r.last);
    endfunction

    task automatic table_predict(input table_cmd_t c);
        mmt_pkg::beat_t r;
        mmt_pkg::beat_t prev;
        logic           have_prev;
        logic           hit;
        logic           found;
        logic [5:0]     nxt;
        int             b;
        int             i;
        int             j;
        r = '0;
        r.last = 1'b1;
        b = int'(c.len) - 1;
        case (c.cmd)
            mmt_pkg::CMD_ADD:
            begin
                if (c.len == 0 || c.len > mmt_pkg::MAX_LEN)
                    r.status = mmt_pkg::ST_BAD_LEN;
                else if (bank_fill[b] >= mmt_pkg::ENTRIES_PER_LENGTH)
                    r.status = mmt_pkg::ST_FULL;
                else
                begin
                    pat_mem[b][bank_fill[b]] = c.ev & byte_keep(c.len);
                    msk_mem[b][bank_fill[b]] = c.mk & byte_keep(c.len);
                    typ_mem[b][bank_fill[b]] = c.ty;
                    val_mem[b][bank_fill[b]] = c.val;
                    bank_fill[b]++;
                    r.status = mmt_pkg::ST_OK;
                end
                results_due.push_back(r);
            end
            mmt_pkg::CMD_LOOKUP:
            begin
                if (c.len == 0 || c.len > mmt_pkg::MAX_LEN)
                begin
                    r.status = mmt_pkg::ST_BAD_LEN;
                    results_due.push_back(r);
                end
                else
                begin
                    have_prev = 1'b0;
                    prev = '0;
                    for (i = 0; i < bank_fill[b]; i++)
                    begin
                        hit = 1'b1;
                        for (j = 0; j < int'(c.len); j++)
                        begin
                            if (msk_mem[b][i][8*j +: 8] != mmt_pkg::WILDCARD_BYTE
                                    && pat_mem[b][i][8*j +: 8] != c.ev[8*j +: 8])
                                hit = 1'b0;
                        end
                        if (hit)
                        begin
                            if (have_prev)
                                results_due.push_back(prev);
                            prev = stored_entry(b, i);
                            prev.last = 1'b0;
                            have_prev = 1'b1;
                        end
                    end
                    if (have_prev)
                    begin
                        prev.last = 1'b1;
                        results_due.push_back(prev);
                    end
                    else
                    begin
                        r.status = mmt_pkg::ST_NONE;
                        results_due.push_back(r);
                    end
                end
            end
            mmt_pkg::CMD_WALK_RESET:
            begin
                walk_bank = 0;
                walk_pos = 6'h3F;
                r.status = mmt_pkg::ST_OK;
                results_due.push_back(r);
            end
            default:
            begin
                found = 1'b0;
                r.status = mmt_pkg::ST_NONE;
                while (walk_bank < mmt_pkg::MAX_EVENT_BYTES && !found)
                begin
                    nxt = walk_pos + 6'd1;
                    if (int'(nxt) >= bank_fill[walk_bank])
                    begin
                        walk_pos = 6'h3F;
                        walk_bank++;
                    end
                    else
                    begin
                        walk_pos = nxt;
                        r = stored_entry(walk_bank, int'(nxt));
                        found = 1'b1;
                    end
                end
                results_due.push_back(r);
            end
        endcase
    endtask

    task automatic queue_cmd(input mmt_pkg::cmd_t cmd, input int len, input logic [63:0] ev,
                             input logic [63:0] mk, input logic [7:0] ty,
                             input logic [31:0] val);
        table_cmd_t c;
        c.cmd = cmd;
        c.len = 4'(len);
        c.ev = ev;
        c.mk = mk;
        c.ty = ty;
        c.val = val;
        pending_cmds.push_back(c);
    endtask

    task automatic queue_add(input int len, input logic [63:0] ev, input logic [63:0] mk,
                             input logic [7:0] ty, input logic [31:0] val);
        queue_cmd(mmt_pkg::CMD_ADD, len, ev, mk, ty, val);
        if (len >= 1 && len <= mmt_pkg::MAX_EVENT_BYTES
                && gen_fill[len-1] < mmt_pkg::ENTRIES_PER_LENGTH)
        begin
            gen_pat[len-1][gen_fill[len-1]] = ev;
            gen_fill[len-1]++;
        end
    endtask

    // sender
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (beat_taken)
            begin
                beat_taken = 1'b0;
                offering = 1'b0;
            end
            if (!offering)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (pending_cmds.size() > 0)
                begin
                    cur = pending_cmds.pop_front();
                    offering = 1'b1;
                    send_gap = ((n_offered / 24) % 4 == 3) ? 0 : $urandom_range(0, 8);
                    n_offered++;
                end
            end
            in_valid <= offering;
            drv_cmd <= cur.cmd;
            drv_len <= cur.len;
            drv_event <= cur.ev;
            drv_mask <= cur.mk;
            drv_type <= cur.ty;
            drv_value <= cur.val;
        end
    end

    // receiver
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (!hold_done && n_in_taken >= HOLD_AFTER)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                table_predict(cur);
                beat_taken = 1'b1;
                n_in_taken++;
            end
            if (out_valid && !out_stall)
            begin
                got_beat.status = mmt_pkg::status_t'(status);
                got_beat.etype = out_type;
                got_beat.value = out_value;
                got_beat.length = out_length;
                got_beat.pattern = out_event;
                got_beat.mask = out_mask;
                got_beat.last = last;
                if (results_due.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected beat: %s", beat_text(got_beat));
                end
                else
                begin
                    due_beat = results_due.pop_front();
                    if (got_beat.status !== due_beat.status
                            || got_beat.etype !== due_beat.etype
                            || got_beat.value !== due_beat.value
                            || got_beat.length !== due_beat.length
                            || got_beat.pattern !== due_beat.pattern
                            || got_beat.mask !== due_beat.mask
                            || got_beat.last !== due_beat.last)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: expected %s\n          actual   %s",
                                     beat_text(due_beat), beat_text(got_beat));
                    end
                end
                n_out++;
                stall_left = ((n_out / 40) % 4 == 3) ? 0 : $urandom_range(0, 8);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        int          n;
        int          pick;
        int          len;
        int          k;
        logic [63:0] ev;
        logic [63:0] keep;

        // empty table, bad lengths
        queue_cmd(mmt_pkg::CMD_WALK_NEXT, 0, '0, '0, '0, '0);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 1, '0, '0, '0, '0);
        queue_add(0, '1, '1, 8'hFF, 32'hFFFF_FFFF);
        queue_add(9, '1, '0, 8'h11, 32'h1);
        queue_add(15, '0, '1, 8'h22, 32'h2);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 0, '1, '1, '1, '1);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 12, '0, '0, '0, '0);

        // exact, wildcard and mixed entries, junk above the length
        queue_add(1, 64'hFFFF_FFFF_FFFF_FFAB, 64'hFFFF_FFFF_FFFF_FF00, 8'hFF, 32'h8000_0000);
        queue_add(8, '1, '1, 8'h00, 32'h7FFF_FFFF);
        queue_add(8, '0, '0, 8'h5A, 32'hFFFF_FFFF);
        queue_add(3, '1, 64'hA5A5_A5A5_A5FF_00FF, 8'h3C, 32'h0);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 1, 64'hFFFF_FFFF_FFFF_FFAB, '0, '0, '0);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 1, 64'h0000_0000_0000_00AC, '0, '0, '0);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 8, '0, '0, '0, '0);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 3, 64'hDEAD_0000_0012_FF34, '0, '0, '0);
        queue_cmd(mmt_pkg::CMD_LOOKUP, 3, 64'h0000_0000_0012_0034, '0, '0, '0);

        // walk through everything and past the end
        queue_cmd(mmt_pkg::CMD_WALK_RESET, 0, '0, '0, '0, '0);
        for (n = 0; n < 6; n++)
            queue_cmd(mmt_pkg::CMD_WALK_NEXT, 0, '0, '0, '0, '0);

        // entry added ahead of the walk
        queue_cmd(mmt_pkg::CMD_WALK_RESET, 0, '1, '1, '1, '1);
        queue_cmd(mmt_pkg::CMD_WALK_NEXT, 0, '0, '0, '0, '0);
        queue_add(2, 64'h0000_0000_0000_C3C3, 64'h0000_0000_0000_FF00, 8'h77, 32'h1234_5678);
        queue_cmd(mmt_pkg::CMD_WALK_NEXT, 0, '0, '0, '0, '0);
        queue_cmd(mmt_pkg::CMD_WALK_NEXT, 0, '0, '0, '0, '0);

        // fill one empty bank with wildcard entries, overflow it, then match all of it
        len = $urandom_range(4, 7);
        while (gen_fill[len-1] < mmt_pkg::ENTRIES_PER_LENGTH)
            queue_add(len, rand64(), rand_mask(4), 8'($urandom), $urandom);
        queue_add(len, rand64(), rand_mask(2), 8'($urandom), $urandom);
        queue_add(len, rand64(), rand_mask(2), 8'($urandom), $urandom);
        queue_cmd(mmt_pkg::CMD_LOOKUP, len, rand64(), rand64(), 8'($urandom), $urandom);

        for (n = 0; n < 200; n++)
        begin
            pick = $urandom_range(0, 19);
            if ($urandom_range(0, 15) == 0)
                len = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(9, 15);
            else
                len = $urandom_range(1, 8);
            if (pick < 7)
                queue_add(len, rand64(), rand_mask(2), 8'($urandom), $urandom);
            else if (pick < 14)
            begin
                ev = rand64();
                if (len >= 1 && len <= 8 && gen_fill[len-1] > 0 && $urandom_range(0, 3) != 0)
                begin
                    keep = byte_keep(len);
                    k = $urandom_range(0, gen_fill[len-1] - 1);
                    ev = (gen_pat[len-1][k] & keep) | (ev & ~keep);
                    if ($urandom_range(0, 2) == 0)
                        ev[8*$urandom_range(0, len - 1) +: 8] = 8'($urandom);
                end
                queue_cmd(mmt_pkg::CMD_LOOKUP, len, ev, rand64(), 8'($urandom), $urandom);
            end
            else if (pick < 16)
                queue_cmd(mmt_pkg::CMD_WALK_RESET, len, rand64(), rand64(), 8'($urandom),
                          $urandom);
            else
                queue_cmd(mmt_pkg::CMD_WALK_NEXT, len, rand64(), rand64(), 8'($urandom),
                          $urandom);
        end

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_cmds.size() != 0 || offering)
            @(posedge clk);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (mismatch_cnt == 0 && results_due.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire
